// ----- rtl/segment_intersection_point_unit_assert.svh -----
// Assertion macros for the segment intersection point unit.
// Depends on nothing; included by modules that check their own pipeline.
`ifndef SEGMENT_INTERSECTION_POINT_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_POINT_UNIT_ASSERT_SVH

// same-cycle implication
`define SIPU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SIPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/sipu_pkg.sv -----
// Types and widths shared by the segment intersection point unit.
// No dependencies.
package sipu_pkg;

    localparam int CW  = 16;          // coordinate width
    localparam int DFW = CW + 1;      // coordinate difference
    localparam int PW  = 2 * DFW;     // cross product term
    localparam int OW  = PW + 1;      // orientation value
    localparam int MW  = OW;          // orientation magnitude
    localparam int DW  = MW + 1;      // divisor
    localparam int NW  = CW + MW;     // scaled numerator / remainder

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
    } seg_word_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] ix;
        logic signed [CW-1:0] iy;
    } pt_word_t;

    // orientation results handed to the scaling stages
    typedef struct packed {
        logic          vld;
        logic          hit;
        logic [MW-1:0] moa;
        logic [DW-1:0] den;
        logic [CW-1:0] dmx;
        logic [CW-1:0] dmy;
        logic          negx;
        logic          negy;
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
    } orient_t;

    // divider pipeline word
    typedef struct packed {
        logic          vld;
        logic          hit;
        logic          negx;
        logic          negy;
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [DW-1:0] den;
        logic [NW-1:0] rx;
        logic [NW-1:0] ry;
        logic [CW-1:0] qx;
        logic [CW-1:0] qy;
    } div_t;

endpackage

// ----- rtl/sipu_orient.sv -----
// Four register stages: differences, cross terms, orientations, hit and divisor.
// Depends on sipu_pkg.
module sipu_orient (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                vld,
    input  sipu_pkg::seg_word_t seg,
    output sipu_pkg::orient_t   ort
);

    localparam int CW  = sipu_pkg::CW;
    localparam int DFW = sipu_pkg::DFW;
    localparam int PW  = sipu_pkg::PW;
    localparam int OW  = sipu_pkg::OW;
    localparam int MW  = sipu_pkg::MW;
    localparam int DW  = sipu_pkg::DW;

    typedef struct packed {
        logic signed [DFW-1:0] ucx, ucy;   // D-C
        logic signed [DFW-1:0] acx, acy;   // A-C
        logic signed [DFW-1:0] bcx, bcy;   // B-C
        logic signed [DFW-1:0] uax, uay;   // B-A
        logic signed [DFW-1:0] cax, cay;   // C-A
        logic signed [DFW-1:0] dax, day;   // D-A
        logic [CW-1:0]         ax, ay;
    } diff_t;

    typedef struct packed {
        logic signed [PW-1:0] pa0, pa1, pb0, pb1, pc0, pc1, pd0, pd1;
        logic signed [DFW-1:0] uax, uay;
        logic [CW-1:0]         ax, ay;
    } prod_t;

    typedef struct packed {
        logic signed [OW-1:0]  oa, ob, oc, od;
        logic signed [DFW-1:0] uax, uay;
        logic [CW-1:0]         ax, ay;
    } ori_t;

    logic  v1_reg, v2_reg, v3_reg, v4_reg;
    diff_t s1_reg, s1_next;
    prod_t s2_reg, s2_next;
    ori_t  s3_reg, s3_next;
    sipu_pkg::orient_t s4_reg, s4_next;

    function automatic logic opposite(input logic signed [OW-1:0] p, input logic signed [OW-1:0] q);
        opposite = (p[OW-1] && !q[OW-1] && (q != '0)) || (q[OW-1] && !p[OW-1] && (p != '0));
    endfunction

    function automatic logic [MW-1:0] magn(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] n;
        n = -v;
        magn = v[OW-1] ? MW'(n) : MW'(v);
    endfunction

    always_comb
    begin
        s1_next.ucx = DFW'(seg.dx) - DFW'(seg.cx);
        s1_next.ucy = DFW'(seg.dy) - DFW'(seg.cy);
        s1_next.acx = DFW'(seg.ax) - DFW'(seg.cx);
        s1_next.acy = DFW'(seg.ay) - DFW'(seg.cy);
        s1_next.bcx = DFW'(seg.bx) - DFW'(seg.cx);
        s1_next.bcy = DFW'(seg.by) - DFW'(seg.cy);
        s1_next.uax = DFW'(seg.bx) - DFW'(seg.ax);
        s1_next.uay = DFW'(seg.by) - DFW'(seg.ay);
        s1_next.cax = DFW'(seg.cx) - DFW'(seg.ax);
        s1_next.cay = DFW'(seg.cy) - DFW'(seg.ay);
        s1_next.dax = DFW'(seg.dx) - DFW'(seg.ax);
        s1_next.day = DFW'(seg.dy) - DFW'(seg.ay);
        s1_next.ax  = seg.ax;
        s1_next.ay  = seg.ay;
    end

    always_comb
    begin
        s2_next.pa0 = PW'(s1_reg.ucx) * PW'(s1_reg.acy);
        s2_next.pa1 = PW'(s1_reg.ucy) * PW'(s1_reg.acx);
        s2_next.pb0 = PW'(s1_reg.ucx) * PW'(s1_reg.bcy);
        s2_next.pb1 = PW'(s1_reg.ucy) * PW'(s1_reg.bcx);
        s2_next.pc0 = PW'(s1_reg.uax) * PW'(s1_reg.cay);
        s2_next.pc1 = PW'(s1_reg.uay) * PW'(s1_reg.cax);
        s2_next.pd0 = PW'(s1_reg.uax) * PW'(s1_reg.day);
        s2_next.pd1 = PW'(s1_reg.uay) * PW'(s1_reg.dax);
        s2_next.uax = s1_reg.uax;
        s2_next.uay = s1_reg.uay;
        s2_next.ax  = s1_reg.ax;
        s2_next.ay  = s1_reg.ay;
    end

    always_comb
    begin
        s3_next.oa  = OW'(s2_reg.pa0) - OW'(s2_reg.pa1);
        s3_next.ob  = OW'(s2_reg.pb0) - OW'(s2_reg.pb1);
        s3_next.oc  = OW'(s2_reg.pc0) - OW'(s2_reg.pc1);
        s3_next.od  = OW'(s2_reg.pd0) - OW'(s2_reg.pd1);
        s3_next.uax = s2_reg.uax;
        s3_next.uay = s2_reg.uay;
        s3_next.ax  = s2_reg.ax;
        s3_next.ay  = s2_reg.ay;
    end

    always_comb
    begin
        logic signed [DFW-1:0] nx, ny;
        logic [MW-1:0]         moa;
        nx = -s3_reg.uax;
        ny = -s3_reg.uay;
        moa = magn(s3_reg.oa);
        s4_next.vld  = v3_reg;
        s4_next.hit  = opposite(s3_reg.oa, s3_reg.ob) && opposite(s3_reg.oc, s3_reg.od);
        s4_next.moa  = moa;
        s4_next.den  = DW'(moa) + DW'(magn(s3_reg.ob));
        s4_next.negx = s3_reg.uax[DFW-1];
        s4_next.negy = s3_reg.uay[DFW-1];
        // magnitude of a coordinate difference always fits CW bits
        s4_next.dmx  = s3_reg.uax[DFW-1] ? nx[CW-1:0] : s3_reg.uax[CW-1:0];
        s4_next.dmy  = s3_reg.uay[DFW-1] ? ny[CW-1:0] : s3_reg.uay[CW-1:0];
        s4_next.ax   = s3_reg.ax;
        s4_next.ay   = s3_reg.ay;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    always_comb
    begin
        ort     = s4_reg;
        ort.vld = v4_reg;
    end

endmodule

// ----- rtl/sipu_scale.sv -----
// Two register stages: |B-A| times |oa| as two partial products, then their sum.
// Depends on sipu_pkg.
module sipu_scale (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  sipu_pkg::orient_t ort,
    output sipu_pkg::div_t    dv
);

    localparam int CW = sipu_pkg::CW;
    localparam int MW = sipu_pkg::MW;
    localparam int NW = sipu_pkg::NW;
    localparam int H  = MW / 2;

    typedef struct packed {
        logic [CW+H-1:0]    plx, ply;
        logic [CW+MW-H-1:0] phx, phy;
    } part_t;

    logic              v5_reg, v6_reg;
    part_t             p_reg, p_next;
    sipu_pkg::orient_t o5_reg;
    sipu_pkg::div_t    d_reg, d_next;

    always_comb
    begin
        p_next.plx = (CW+H)'(ort.dmx) * (CW+H)'(ort.moa[H-1:0]);
        p_next.ply = (CW+H)'(ort.dmy) * (CW+H)'(ort.moa[H-1:0]);
        p_next.phx = (CW+MW-H)'(ort.dmx) * (CW+MW-H)'(ort.moa[MW-1:H]);
        p_next.phy = (CW+MW-H)'(ort.dmy) * (CW+MW-H)'(ort.moa[MW-1:H]);
    end

    always_comb
    begin
        d_next.vld  = v5_reg;
        d_next.hit  = o5_reg.hit;
        d_next.negx = o5_reg.negx;
        d_next.negy = o5_reg.negy;
        d_next.ax   = o5_reg.ax;
        d_next.ay   = o5_reg.ay;
        d_next.den  = o5_reg.den;
        d_next.rx   = NW'(p_reg.plx) + (NW'(p_reg.phx) << H);
        d_next.ry   = NW'(p_reg.ply) + (NW'(p_reg.phy) << H);
        d_next.qx   = '0;
        d_next.qy   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= ort.vld;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg  <= p_next;
            o5_reg <= ort;
            d_reg  <= d_next;
        end
    end

    always_comb
    begin
        dv     = d_reg;
        dv.vld = v6_reg;
    end

endmodule

// ----- rtl/sipu_div_stage.sv -----
// One restoring divide step: quotient bit BIT for both axes.
// Depends on sipu_pkg.
module sipu_div_stage #(
    parameter int BIT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  sipu_pkg::div_t din,
    output sipu_pkg::div_t dout
);

    localparam int NW = sipu_pkg::NW;

    logic           vld_reg;
    sipu_pkg::div_t d_reg, d_next;

    always_comb
    begin
        logic [NW-1:0] sd;
        sd = NW'(din.den) << BIT;
        d_next = din;
        if (din.rx >= sd)
        begin
            d_next.rx      = din.rx - sd;
            d_next.qx[BIT] = 1'b1;
        end
        if (din.ry >= sd)
        begin
            d_next.ry      = din.ry - sd;
            d_next.qy[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= din.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            d_reg <= d_next;
    end

    always_comb
    begin
        dout     = d_reg;
        dout.vld = vld_reg;
    end

endmodule

// ----- rtl/segment_intersection_point_unit.sv -----
// Pipeline: orientation stages, scaling stages, one divide stage per quotient bit, then an output register.
// Throughput: one word per cycle; the whole pipeline holds while a result is stalled.
// Quotient is formed one bit per stage, so depth grows with the coordinate width.
// Reset clears all valid bits; data registers are not reset.
// Depends on sipu_pkg, sipu_orient, sipu_scale, sipu_div_stage.
module segment_intersection_point_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seg_valid,
    output logic                seg_stall,
    input  sipu_pkg::seg_word_t seg,
    output logic                pt_valid,
    input  logic                pt_stall,
    output sipu_pkg::pt_word_t  pt
);

    `include "segment_intersection_point_unit_assert.svh"

    localparam int CW = sipu_pkg::CW;

    logic               adv;
    logic               pt_valid_reg;
    sipu_pkg::pt_word_t pt_reg, pt_next;
    sipu_pkg::orient_t  ort;
    sipu_pkg::div_t     dchain [CW+1];

    assign adv       = !(pt_valid_reg && pt_stall);
    assign seg_stall = !adv;

    sipu_orient u_orient (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .vld   (seg_valid),
        .seg   (seg),
        .ort   (ort)
    );

    sipu_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .ort   (ort),
        .dv    (dchain[0])
    );

    // most significant quotient bit first
    for (genvar k = 0; k < CW; k++)
    begin : g_div
        sipu_div_stage #(
            .BIT (CW - 1 - k)
        ) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .din   (dchain[k]),
            .dout  (dchain[k+1])
        );
    end

    always_comb
    begin
        sipu_pkg::div_t d;
        d = dchain[CW];
        pt_next.hit = d.hit;
        pt_next.ix  = '0;
        pt_next.iy  = '0;
        if (d.hit)
        begin
            pt_next.ix = d.negx ? d.ax - d.qx : d.ax + d.qx;
            pt_next.iy = d.negy ? d.ay - d.qy : d.ay + d.qy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pt_valid_reg <= 1'b0;
        else if (adv)
            pt_valid_reg <= dchain[CW].vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pt_reg <= pt_next;
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

    `SIPU_ASSERT_NOW(a_miss_zero, clk, rst_n, pt_valid_reg && !pt_reg.hit,
        pt_reg.ix == '0 && pt_reg.iy == '0)
    `SIPU_ASSERT_NEXT(a_out_hold, clk, rst_n, pt_valid_reg && pt_stall,
        pt_valid_reg && $stable(pt_reg))
    `SIPU_ASSERT_NEXT(a_drain, clk, rst_n, adv && dchain[CW].vld, pt_valid_reg)
    `SIPU_ASSERT_NEXT(a_hold, clk, rst_n, !adv && dchain[CW].vld, dchain[CW].vld)

endmodule
